[rtl/rslot_pkg.sv]
// Shared types and constants for the rectangle slot table.
`timescale 1ns / 1ps

package rslot_pkg;

  localparam int OP_W   = 3;
  localparam int SLOT_W = 5;
  localparam int POS_W  = 15;
  localparam int SIZE_W = 14;
  localparam int PT_W   = 16;
  localparam int EDGE_W = 16;
  localparam int CMP_W  = 17;

  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OP_W-1:0] OP_OVERLAP = 3'd2;
  localparam logic [OP_W-1:0] OP_POINT   = 3'd3;
  localparam logic [OP_W-1:0] OP_CORNER  = 3'd4;

  // Stored rectangle: left/top edge and exclusive right/bottom edge.
  typedef struct packed {
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [EDGE_W-1:0] rx;
    logic [EDGE_W-1:0] by;
  } geom_t;

  typedef struct packed {
    logic [CMP_W-1:0] ox;
    logic [CMP_W-1:0] oy;
  } anchor_t;

endpackage

[rtl/rslot_if.sv]
// Request and response channel interfaces for the rectangle slot table.
`timescale 1ns / 1ps

interface rslot_req_if import rslot_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SLOT_W-1:0] slot;
  logic              skip_valid;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [PT_W-1:0]   point_x;
  logic [PT_W-1:0]   point_y;

  modport source (output valid, op, slot, skip_valid, pos_x, pos_y, size_x, size_y,
                  point_x, point_y, input ready);
  modport sink (input valid, op, slot, skip_valid, pos_x, pos_y, size_x, size_y,
                point_x, point_y, output ready);
endinterface

interface rslot_rsp_if import rslot_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot_out;
  logic [PT_W-1:0]   origin_x;
  logic [PT_W-1:0]   origin_y;

  modport source (output valid, hit, slot_out, origin_x, origin_y, input ready);
  modport sink (input valid, hit, slot_out, origin_x, origin_y, output ready);
endinterface

[rtl/rectangle_slot_table.sv]
// Rectangle slot table: insert, delete, overlap, point and corner queries.
//
//   channel | dir | payload                                                  | transfer
//   req     | in  | op slot skip_valid pos_x pos_y size_x size_y point_x/y  | valid & ready
//   rsp     | out | hit slot_out origin_x origin_y                           | valid & ready
//
// Delete and unknown ops go straight from idle to the finish step; insert scans the used
// flags from slot 0 for the first free slot; overlap, point and corner queries scan the
// single-port geometry memory one slot per cycle through one shared compare stage.
// Reset clears all used flags at once; no clearing pass. req is taken only while the
// sequencer is idle; a waiting result in the rsp register holds only the final step.
`timescale 1ns / 1ps

module rectangle_slot_table import rslot_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  rslot_req_if.sink   req,
  rslot_rsp_if.source rsp
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = (IW > SLOT_W) ? IW : SLOT_W;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]        state;
  logic [OP_W-1:0]   op_q;
  logic [SLOT_W-1:0] slot_q;
  logic              skip_q;
  geom_t             q_geom;
  logic [PT_W-1:0]   x_q;
  logic [PT_W-1:0]   y_q;
  logic [CMP_W-1:0]  x1_q;
  logic [CMP_W-1:0]  y1_q;
  logic [IW-1:0]     idx;
  logic              issue;
  logic              cv;
  logic [IW-1:0]     cidx;
  logic              cused;
  geom_t             rd_geom;
  logic [SLOTS-1:0]  used;
  logic              res_hit;
  logic [SLOT_W-1:0] res_slot;
  logic [PT_W-1:0]   res_ox;
  logic [PT_W-1:0]   res_oy;

  geom_t   geom_mem [SLOTS];
  anchor_t anchor_mem [SLOTS];

  logic              accept;
  geom_t             new_geom;
  logic [CW-1:0]     del_ext;
  logic              del_ok;
  logic [CW-1:0]     idx_ext;
  logic [CW-1:0]     cidx_ext;
  logic [CMP_W-1:0]  epx, epy, erx, eby, err, ebb;
  logic [CMP_W-1:0]  qpx, qpy, qrx, qby, xs, ys;
  logic              ov_hit, pt_hit, skip_hit;
  logic              xl, xr, yt, yb;
  logic              cn_hit;
  logic [CMP_W-1:0]  cn_ox, cn_oy;
  logic              entry_match;
  logic              found;
  logic              ins_claim;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  assign new_geom.px = req.pos_x;
  assign new_geom.py = req.pos_y;
  assign new_geom.rx = {req.pos_x[POS_W-1], req.pos_x} + {2'b00, req.size_x};
  assign new_geom.by = {req.pos_y[POS_W-1], req.pos_y} + {2'b00, req.size_y};

  assign del_ext  = CW'(req.slot);
  assign del_ok   = (32'(del_ext) < SLOTS) && used[del_ext[IW-1:0]];
  assign idx_ext  = CW'(idx);
  assign cidx_ext = CW'(cidx);

  assign epx = {{2{rd_geom.px[POS_W-1]}}, rd_geom.px};
  assign epy = {{2{rd_geom.py[POS_W-1]}}, rd_geom.py};
  assign erx = {rd_geom.rx[EDGE_W-1], rd_geom.rx};
  assign eby = {rd_geom.by[EDGE_W-1], rd_geom.by};
  assign err = erx - CMP_W'(1);
  assign ebb = eby - CMP_W'(1);
  assign qpx = {{2{q_geom.px[POS_W-1]}}, q_geom.px};
  assign qpy = {{2{q_geom.py[POS_W-1]}}, q_geom.py};
  assign qrx = {q_geom.rx[EDGE_W-1], q_geom.rx};
  assign qby = {q_geom.by[EDGE_W-1], q_geom.by};
  assign xs  = {x_q[PT_W-1], x_q};
  assign ys  = {y_q[PT_W-1], y_q};

  assign ov_hit = !(($signed(qby) <= $signed(epy)) || ($signed(eby) <= $signed(qpy)) ||
                    ($signed(qrx) <= $signed(epx)) || ($signed(erx) <= $signed(qpx)));
  assign pt_hit = ($signed(xs) >= $signed(epx)) && ($signed(ys) >= $signed(epy)) &&
                  ($signed(xs) < $signed(erx)) && ($signed(ys) < $signed(eby));
  assign skip_hit = skip_q && (cidx_ext == CW'(slot_q));

  assign xl = (xs == epx);
  assign xr = (x1_q == erx);
  assign yt = (ys == epy);
  assign yb = (y1_q == eby);

  always_comb begin
    cn_hit = 1'b1;
    cn_ox  = '0;
    cn_oy  = '0;
    if (xl && yt) begin
      cn_ox = err;
      cn_oy = ebb;
    end else if (xr && yt) begin
      cn_ox = epx;
      cn_oy = ebb;
    end else if (xr && yb) begin
      cn_ox = epx;
      cn_oy = epy;
    end else if (xl && yb) begin
      cn_ox = err;
      cn_oy = epy;
    end else begin
      cn_hit = 1'b0;
    end
  end

  always_comb begin
    case (op_q)
      OP_OVERLAP: entry_match = ov_hit && !skip_hit;
      OP_POINT:   entry_match = pt_hit;
      OP_CORNER:  entry_match = cn_hit;
      default:    entry_match = 1'b0;
    endcase
  end

  assign found     = (state == ST_SCAN) && cv && cused && entry_match;
  assign ins_claim = (state == ST_SCAN) && (op_q == OP_INSERT) && !used[idx];

  // Geometry and anchor memories.
  always_ff @(posedge clk) begin
    rd_geom <= geom_mem[idx];
    if (ins_claim) begin
      geom_mem[idx] <= q_geom;
    end
    if (found && (op_q == OP_CORNER)) begin
      anchor_mem[cidx] <= '{ox: cn_ox, oy: cn_oy};
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
      issue     <= 1'b0;
      cv        <= 1'b0;
      used      <= '0;
    end else begin
      if (rsp.valid && rsp.ready && (state != ST_FINISH)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_q     <= req.op;
            slot_q   <= req.slot;
            skip_q   <= req.skip_valid;
            q_geom   <= new_geom;
            x_q      <= req.point_x;
            y_q      <= req.point_y;
            x1_q     <= {req.point_x[PT_W-1], req.point_x} + CMP_W'(1);
            y1_q     <= {req.point_y[PT_W-1], req.point_y} + CMP_W'(1);
            idx      <= '0;
            cv       <= 1'b0;
            res_ox   <= '0;
            res_oy   <= '0;
            case (req.op)
              OP_INSERT, OP_OVERLAP, OP_POINT, OP_CORNER: begin
                res_hit  <= 1'b0;
                res_slot <= '0;
                issue    <= 1'b1;
                state    <= ST_SCAN;
              end
              OP_DELETE: begin
                if (del_ok) begin
                  used[del_ext[IW-1:0]] <= 1'b0;
                  res_hit  <= 1'b1;
                  res_slot <= req.slot;
                end else begin
                  res_hit  <= 1'b0;
                  res_slot <= '0;
                end
                state <= ST_FINISH;
              end
              default: begin
                res_hit  <= 1'b0;
                res_slot <= '0;
                state    <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (op_q == OP_INSERT) begin
            if (ins_claim) begin
              used[idx] <= 1'b1;
              res_hit   <= 1'b1;
              res_slot  <= idx_ext[SLOT_W-1:0];
              state     <= ST_FINISH;
            end else if (idx == LAST) begin
              state <= ST_FINISH;
            end else begin
              idx <= idx + IW'(1);
            end
          end else if (found) begin
            res_hit  <= 1'b1;
            res_slot <= cidx_ext[SLOT_W-1:0];
            if (op_q == OP_CORNER) begin
              res_ox <= cn_ox[PT_W-1:0];
              res_oy <= cn_oy[PT_W-1:0];
            end
            cv    <= 1'b0;
            issue <= 1'b0;
            state <= ST_FINISH;
          end else if (cv && (cidx == LAST)) begin
            cv    <= 1'b0;
            state <= ST_FINISH;
          end else begin
            cv    <= issue;
            cidx  <= idx;
            cused <= used[idx];
            if (issue) begin
              if (idx == LAST) begin
                issue <= 1'b0;
              end else begin
                idx <= idx + IW'(1);
              end
            end
          end
        end
        ST_FINISH: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid    <= 1'b1;
            rsp.hit      <= res_hit;
            rsp.slot_out <= res_slot;
            rsp.origin_x <= res_ox;
            rsp.origin_y <= res_oy;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.hit |-> rsp.slot_out == '0 && rsp.origin_x == '0 &&
                               rsp.origin_y == '0)
    else $error("miss result carries nonzero fields");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ins_claim |=> $countones(used) == $past($countones(used)) + 1)
    else $error("insert did not claim exactly one slot");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (rst)
    cv |-> state == ST_SCAN)
    else $error("compare stage active outside scan");

  a_idle_no_issue: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |=> !cv)
    else $error("compare stage left running after scan");

endmodule

[test/tb_rectangle_slot_table.sv]
// Testbench for the rectangle slot table: directed table, random traffic, result checking.
`timescale 1ns / 1ps

module tb_rectangle_slot_table;
  import rslot_pkg::*;

  localparam int SLOTS = 32;
  localparam logic [OP_W-1:0] OP_NONE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_NONE_LAST  = 3'd7;
  localparam int SEND_IDLE[4]   = '{0, 50, 0, 15};
  localparam int RECV_STALL[4]  = '{0, 0, 50, 15};
  localparam int PHASE_ITEMS[4] = '{350, 300, 300, 350};
  localparam int HOLD_CYCLES    = 400;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic              skip;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    logic [PT_W-1:0]   qx;
    logic [PT_W-1:0]   qy;
  } request_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [PT_W-1:0]   ox;
    logic [PT_W-1:0]   oy;
  } answer_t;

  typedef struct {
    request_t rq;
    bit       typed;
    answer_t  ans;
  } plan_row_t;

  typedef struct {
    int px;
    int py;
    int sx;
    int sy;
  } rect_t;

  localparam answer_t MISS = '0;

  logic clk = 1'b0;
  logic rst;

  rslot_req_if req ();
  rslot_rsp_if rsp ();

  rectangle_slot_table #(.SLOTS(SLOTS)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  bit      occupied[SLOTS];
  rect_t   shapes[SLOTS];
  anchor_t anchors[SLOTS];
  bit      filling = 1'b1;
  answer_t answers_due[$];
  int      errors = 0;
  int      send_idle = 0;
  int      stall_pct = 0;
  bit      hold_rsp = 1'b0;

  function automatic request_t mk_req(logic [OP_W-1:0] op, int slot, bit skip, int px, int py,
                                      int sx, int sy, int qx, int qy);
    request_t rq;
    rq.op   = op;
    rq.slot = SLOT_W'(slot);
    rq.skip = skip;
    rq.px   = POS_W'(px);
    rq.py   = POS_W'(py);
    rq.sx   = SIZE_W'(sx);
    rq.sy   = SIZE_W'(sy);
    rq.qx   = PT_W'(qx);
    rq.qy   = PT_W'(qy);
    return rq;
  endfunction

  function automatic answer_t hit_at(int slot, int ox, int oy);
    answer_t a;
    a.hit  = 1'b1;
    a.slot = SLOT_W'(slot);
    a.ox   = PT_W'(ox);
    a.oy   = PT_W'(oy);
    return a;
  endfunction

  function automatic answer_t slot_table_step(request_t rq);
    answer_t ans;
    rect_t   q;
    int      i, x, y, l, t, r, b, ox, oy;
    bit      found;
    ans   = '0;
    found = 1'b0;
    ox    = 0;
    oy    = 0;
    q.px  = int'($signed(rq.px));
    q.py  = int'($signed(rq.py));
    q.sx  = int'(rq.sx);
    q.sy  = int'(rq.sy);
    x     = int'($signed(rq.qx));
    y     = int'($signed(rq.qy));
    case (rq.op)
      OP_INSERT: begin
        for (i = 0; i < SLOTS && !found; i++) begin
          if (!occupied[i]) begin
            occupied[i] = 1'b1;
            shapes[i]   = q;
            found       = 1'b1;
            ans.slot    = SLOT_W'(i);
          end
        end
      end
      OP_DELETE: begin
        if (int'(rq.slot) < SLOTS && occupied[rq.slot]) begin
          occupied[rq.slot] = 1'b0;
          found             = 1'b1;
          ans.slot          = rq.slot;
        end
      end
      OP_OVERLAP: begin
        for (i = 0; i < SLOTS && !found; i++) begin
          if (occupied[i] && !(rq.skip && i == int'(rq.slot)) &&
              !(q.py + q.sy <= shapes[i].py || shapes[i].py + shapes[i].sy <= q.py ||
                q.px + q.sx <= shapes[i].px || shapes[i].px + shapes[i].sx <= q.px)) begin
            found    = 1'b1;
            ans.slot = SLOT_W'(i);
          end
        end
      end
      OP_POINT: begin
        for (i = 0; i < SLOTS && !found; i++) begin
          if (occupied[i] && x >= shapes[i].px && y >= shapes[i].py &&
              x < shapes[i].px + shapes[i].sx && y < shapes[i].py + shapes[i].sy) begin
            found    = 1'b1;
            ans.slot = SLOT_W'(i);
          end
        end
      end
      OP_CORNER: begin
        for (i = 0; i < SLOTS && !found; i++) begin
          if (occupied[i]) begin
            l     = shapes[i].px;
            t     = shapes[i].py;
            r     = l + shapes[i].sx - 1;
            b     = t + shapes[i].sy - 1;
            found = 1'b1;
            if (x == l && y == t) begin
              ox = r;
              oy = b;
            end else if (x == r && y == t) begin
              ox = l;
              oy = b;
            end else if (x == r && y == b) begin
              ox = l;
              oy = t;
            end else if (x == l && y == b) begin
              ox = r;
              oy = t;
            end else begin
              found = 1'b0;
            end
            if (found) begin
              anchors[i].ox = CMP_W'(ox);
              anchors[i].oy = CMP_W'(oy);
              ans.slot      = SLOT_W'(i);
            end
          end
        end
      end
      default: begin
      end
    endcase
    ans.hit = found;
    ans.ox  = PT_W'(ox);
    ans.oy  = PT_W'(oy);
    return ans;
  endfunction

  function automatic int near_edge(int lo, int span);
    case ($urandom_range(4))
      0: return lo - 1;
      1: return lo;
      2: return lo + span - 1;
      3: return lo + span;
      default: return lo + int'($urandom_range(span > 0 ? span - 1 : 0));
    endcase
  endfunction

  function automatic logic [OP_W-1:0] OP_OP_NONE_PICK();
    return OP_W'($urandom_range(OP_NONE_LAST, OP_NONE_FIRST));
  endfunction

  function automatic request_t random_request();
    logic [OP_W-1:0] op;
    int              n, s, k, i, c, slot, px, py, sx, sy, qx, qy;
    bit              skip;
    n = 0;
    for (i = 0; i < SLOTS; i++) n += int'(occupied[i]);
    if (n == SLOTS && $urandom_range(7) == 0) filling = 1'b0;
    if (n <= 2) filling = 1'b1;
    s = -1;
    if (n > 0) begin
      k = int'($urandom_range(n - 1));
      for (i = 0; i < SLOTS; i++) begin
        if (occupied[i]) begin
          if (k == 0) s = i;
          k--;
        end
      end
    end
    k = int'($urandom_range(99));
    if (k < 4) op = OP_OP_NONE_PICK();
    else if (k < (filling ? 40 : 16)) op = OP_INSERT;
    else if (k < 52) op = OP_DELETE;
    else if (k < 68) op = OP_OVERLAP;
    else if (k < 84) op = OP_POINT;
    else op = OP_CORNER;
    slot = int'($urandom_range(SLOTS - 1));
    skip = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      px = int'($urandom_range(32767)) - 16384;
      py = int'($urandom_range(32767)) - 16384;
      sx = int'($urandom_range(16383));
      sy = int'($urandom_range(16383));
    end else begin
      px = int'($urandom_range(120)) - 60;
      py = int'($urandom_range(120)) - 60;
      sx = int'($urandom_range(30));
      sy = int'($urandom_range(30));
    end
    if ($urandom_range(9) == 0) begin
      qx = int'($urandom_range(65535)) - 32768;
      qy = int'($urandom_range(65535)) - 32768;
    end else begin
      qx = int'($urandom_range(140)) - 70;
      qy = int'($urandom_range(140)) - 70;
    end
    if (s >= 0 && $urandom_range(3) != 0) begin
      case (op)
        OP_DELETE: slot = s;
        OP_OVERLAP: begin
          px = shapes[s].px - sx - 1 + int'($urandom_range(shapes[s].sx + sx + 2));
          py = shapes[s].py - sy - 1 + int'($urandom_range(shapes[s].sy + sy + 2));
          if ($urandom_range(1) == 0) slot = s;
        end
        OP_POINT: begin
          qx = near_edge(shapes[s].px, shapes[s].sx);
          qy = near_edge(shapes[s].py, shapes[s].sy);
        end
        OP_CORNER: begin
          c  = int'($urandom_range(3));
          qx = (c == 0 || c == 3) ? shapes[s].px : shapes[s].px + shapes[s].sx - 1;
          qy = (c < 2) ? shapes[s].py : shapes[s].py + shapes[s].sy - 1;
          if ($urandom_range(7) == 0) qx = qx + 1;
          if ($urandom_range(7) == 0) qy = qy - 1;
        end
        default: begin
        end
      endcase
    end
    return mk_req(op, slot, skip, px, py, sx, sy, qx, qy);
  endfunction

  task automatic offer(request_t rq, bit typed, answer_t given);
    answer_t model;
    int      gap;
    gap = 0;
    req.valid      <= 1'b1;
    req.op         <= rq.op;
    req.slot       <= rq.slot;
    req.skip_valid <= rq.skip;
    req.pos_x      <= rq.px;
    req.pos_y      <= rq.py;
    req.size_x     <= rq.sx;
    req.size_y     <= rq.sy;
    req.point_x    <= rq.qx;
    req.point_y    <= rq.qy;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    model = slot_table_step(rq);
    answers_due.push_back(typed ? given : model);
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic flag(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s expected %0h got %0h", $time, what, want, got);
  endtask

  initial begin : drive_ready
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    answer_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (answers_due.size() == 0) begin
        flag("result with none outstanding, slot", 32'hFFFF_FFFF, 32'(rsp.slot_out));
      end else begin
        want = answers_due.pop_front();
        if (rsp.hit !== want.hit) flag("hit", 32'(want.hit), 32'(rsp.hit));
        if (rsp.slot_out !== want.slot) flag("slot_out", 32'(want.slot), 32'(rsp.slot_out));
        if (rsp.origin_x !== want.ox) flag("origin_x", 32'(want.ox), 32'(rsp.origin_x));
        if (rsp.origin_y !== want.oy) flag("origin_y", 32'(want.oy), 32'(rsp.origin_y));
      end
    end
  end

  initial begin : stimulus
    plan_row_t steps[$];
    int        ph, n;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.op         = '0;
    req.slot       = '0;
    req.skip_valid = 1'b0;
    req.pos_x      = '0;
    req.pos_y      = '0;
    req.size_x     = '0;
    req.size_y     = '0;
    req.point_x    = '0;
    req.point_y    = '0;

    steps.push_back('{mk_req(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, MISS});
    steps.push_back('{mk_req(OP_OVERLAP, 0, 0, -16384, -16384, 16383, 16383, 0, 0), 1'b1, MISS});
    steps.push_back('{mk_req(OP_INSERT, 0, 0, -16384, -16384, 16383, 16383, 0, 0), 1'b1,
                      hit_at(0, 0, 0)});
    steps.push_back('{mk_req(OP_INSERT, 0, 0, 16383, 16383, 16383, 16383, 0, 0), 1'b1,
                      hit_at(1, 0, 0)});
    steps.push_back('{mk_req(OP_INSERT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, hit_at(2, 0, 0)});
    steps.push_back('{mk_req(OP_INSERT, 0, 0, 100, 100, 1, 1, 0, 0), 1'b1, hit_at(3, 0, 0)});
    steps.push_back('{mk_req(OP_POINT, 0, 0, 0, 0, 0, 0, -16384, -16384), 1'b1, hit_at(0, 0, 0)});
    steps.push_back('{mk_req(OP_POINT, 0, 0, 0, 0, 0, 0, 32765, 32765), 1'b1, hit_at(1, 0, 0)});
    steps.push_back('{mk_req(OP_POINT, 0, 0, 0, 0, 0, 0, 32766, 32766), 1'b1, MISS});
    steps.push_back('{mk_req(OP_POINT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, MISS});
    steps.push_back('{mk_req(OP_CORNER, 0, 0, 0, 0, 0, 0, -16384, -16384), 1'b1,
                      hit_at(0, -2, -2)});
    steps.push_back('{mk_req(OP_CORNER, 0, 0, 0, 0, 0, 0, 32765, 16383), 1'b1,
                      hit_at(1, 16383, 32765)});
    steps.push_back('{mk_req(OP_CORNER, 0, 0, 0, 0, 0, 0, 100, 100), 1'b1, hit_at(3, 100, 100)});
    steps.push_back('{mk_req(OP_CORNER, 0, 0, 0, 0, 0, 0, -1, 0), 1'b1, hit_at(2, 0, -1)});
    steps.push_back('{mk_req(OP_CORNER, 0, 0, 0, 0, 0, 0, -1, -1), 1'b1, hit_at(2, 0, 0)});
    steps.push_back('{mk_req(OP_CORNER, 0, 0, 0, 0, 0, 0, 0, -1), 1'b1, hit_at(2, -1, 0)});
    steps.push_back('{mk_req(OP_OVERLAP, 31, 1, -16384, -16384, 1, 1, 0, 0), 1'b1,
                      hit_at(0, 0, 0)});
    steps.push_back('{mk_req(OP_OVERLAP, 0, 1, -16384, -16384, 1, 1, 0, 0), 1'b1, MISS});
    steps.push_back('{mk_req(OP_OVERLAP, 0, 0, 16383, 16383, 0, 0, 0, 0), 1'b1, MISS});
    steps.push_back('{mk_req(OP_DELETE, 2, 0, 0, 0, 0, 0, 0, 0), 1'b1, hit_at(2, 0, 0)});
    steps.push_back('{mk_req(OP_DELETE, 2, 0, 0, 0, 0, 0, 0, 0), 1'b1, MISS});
    steps.push_back('{mk_req(OP_DELETE, 31, 0, 0, 0, 0, 0, 0, 0), 1'b1, MISS});
    steps.push_back('{mk_req(OP_NONE_FIRST, 31, 1, 16383, 16383, 16383, 16383, 32767, 32767),
                      1'b1, MISS});
    steps.push_back('{mk_req(OP_NONE_LAST, 31, 1, -1, -1, 16383, 16383, -1, -1), 1'b1, MISS});
    steps.push_back('{mk_req(OP_INSERT, 0, 0, 5, -7, 3, 2, 0, 0), 1'b1, hit_at(2, 0, 0)});
    steps.push_back('{mk_req(OP_POINT, 0, 0, 0, 0, 0, 0, 6, -6), 1'b0, MISS});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[j]) offer(steps[j].rq, steps[j].typed, steps[j].ans);

    for (ph = 0; ph < 4; ph++) begin
      send_idle = SEND_IDLE[ph];
      stall_pct = RECV_STALL[ph];
      if (ph == 0) begin
        fork
          begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rsp <= 1'b0;
          end
        join_none
      end
      for (n = 0; n < PHASE_ITEMS[ph]; n++) offer(random_request(), 1'b0, MISS);
    end
    req.valid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb_rectangle_slot_table: clean");
    end else begin
      $display("tb_rectangle_slot_table: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("tb_rectangle_slot_table: errors");
    $finish;
  end

endmodule

[rectangle_slot_table.f]
rtl/rslot_pkg.sv
rtl/rslot_if.sv
rtl/rectangle_slot_table.sv
test/tb_rectangle_slot_table.sv
